// File: sv/bgc_pkg.sv
package bgc_pkg;

  // Default sizes of the graph store
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF    = 4096;

  // Fixed field widths
  localparam int unsigned VTX_W   = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned APB_AW  = 2;
  localparam int unsigned APB_DW  = 32;

  // Register map
  localparam logic [APB_AW-1:0] REG_ADDR_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_W-1:0]  VERTEX_COUNT_RESET    = 11'd1024;

  // Vertex colors
  localparam logic [1:0] COLOR_NONE = 2'd0;
  localparam logic [1:0] COLOR_ONE  = 2'd1;
  localparam logic [1:0] COLOR_TWO  = 2'd2;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_RD_HA,
    CMD_WR_A,
    CMD_RD_HB,
    CMD_WR_B,
    CMD_SCAN_RD,
    CMD_START,
    CMD_ROOT,
    CMD_NEXT_V,
    CMD_ENT_RD,
    CMD_ENT,
    CMD_PUSH_WR,
    CMD_PUSH,
    CMD_POP_RD
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic pop;     // load top frame from stack read data
    logic fail;    // record a coloring conflict
    logic finish;  // load result register and start the clearing sweep
  } dp_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic last;
    logic clr_last;
    logic scan_done;
    logic scan_free;
    logic cur_null;
    logic depth_one;
    logic nb_skip;
    logic nb_free;
    logic nb_conflict;
    logic out_busy;
  } dp_status_t;

endpackage

// File: sv/bgc_if.sv
interface bgc_edge_if import bgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] end_a;
  logic [VTX_W-1:0] end_b;
  logic             last_edge;

  modport source (output valid, end_a, end_b, last_edge, input ready);
  modport sink   (input valid, end_a, end_b, last_edge, output ready);
endinterface

interface bgc_result_if import bgc_pkg::*; ();
  logic valid;
  logic ready;
  logic is_bipartite;
  logic load_error;

  modport source (output valid, is_bipartite, load_error, input ready);
  modport sink   (input valid, is_bipartite, load_error, output ready);
endinterface

// File: sv/bgc_ram.sv
module bgc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/bgc_ctrl.sv
module bgc_ctrl import bgc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_RDA      = 15'h0004,
    S_WRA      = 15'h0008,
    S_RDB      = 15'h0010,
    S_WRB      = 15'h0020,
    S_SCAN_RD  = 15'h0040,
    S_SCAN_CHK = 15'h0080,
    S_ROOT     = 15'h0100,
    S_STEP     = 15'h0200,
    S_ENT      = 15'h0400,
    S_NBC      = 15'h0800,
    S_PUSH     = 15'h1000,
    S_POP      = 15'h2000,
    S_FINISH   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence the load, the walk and the clearing sweep
  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: CMD_NONE, pop: 1'b0, fail: 1'b0, finish: 1'b0};
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_ACCEPT;
          state_d  = S_RDA;
        end
      end
      S_RDA: begin
        if (status_i.edge_ok) begin
          cmd_o.op = CMD_RD_HA;
          state_d  = S_WRA;
        end else if (status_i.last) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRA: begin
        cmd_o.op = CMD_WR_A;
        state_d  = S_RDB;
      end
      S_RDB: begin
        cmd_o.op = CMD_RD_HB;
        state_d  = S_WRB;
      end
      S_WRB: begin
        cmd_o.op = CMD_WR_B;
        state_d  = status_i.last ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        if (status_i.scan_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_SCAN_RD;
          state_d  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (status_i.scan_free) begin
          cmd_o.op = CMD_START;
          state_d  = S_ROOT;
        end else begin
          cmd_o.op = CMD_NEXT_V;
          state_d  = S_SCAN_RD;
        end
      end
      S_ROOT: begin
        cmd_o.op = CMD_ROOT;
        state_d  = S_STEP;
      end
      S_STEP: begin
        if (!status_i.cur_null) begin
          cmd_o.op = CMD_ENT_RD;
          state_d  = S_ENT;
        end else if (status_i.depth_one) begin
          cmd_o.op = CMD_NEXT_V;
          state_d  = S_SCAN_RD;
        end else begin
          cmd_o.op = CMD_POP_RD;
          state_d  = S_POP;
        end
      end
      S_ENT: begin
        cmd_o.op = CMD_ENT;
        state_d  = status_i.nb_skip ? S_STEP : S_NBC;
      end
      S_NBC: begin
        if (status_i.nb_free) begin
          cmd_o.op = CMD_PUSH_WR;
          state_d  = S_PUSH;
        end else if (status_i.nb_conflict) begin
          cmd_o.fail = 1'b1;
          state_d    = S_FINISH;
        end else begin
          state_d = S_STEP;
        end
      end
      S_PUSH: begin
        cmd_o.op = CMD_PUSH;
        state_d  = S_STEP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_STEP;
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_CLEAR;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Input is taken only between items; an accept always starts the load sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CMD_ACCEPT) |=> (state_q == S_RDA))
    else $error("accept did not start the load sequence");

  // A finished check always goes through the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_CLEAR))
    else $error("result issued without clearing sweep");

  // State register stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

// File: sv/bgc_dp.sv
module bgc_dp import bgc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] vertex_count_i,
  input  logic [VTX_W-1:0] end_a_i,
  input  logic [VTX_W-1:0] end_b_i,
  input  logic             last_edge_i,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_bipartite_o,
  output logic             load_error_o
);

  localparam int unsigned ED  = 2 * MAX_EDGES;
  localparam int unsigned VIW = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EIW = (ED > 1) ? $clog2(ED) : 1;
  localparam int unsigned PW  = $clog2(ED + 1);
  localparam int unsigned FW  = VIW + PW + 2;
  localparam int unsigned EW  = VTX_W + PW;

  // Load registers
  logic [VTX_W-1:0] a_q, b_q;
  logic             last_q, edge_ok_q, error_q, ok_q;
  logic [PW-1:0]    e_q;
  // Walk registers
  logic [NW-1:0]    v_q, depth_q;
  logic [VIW-1:0]   top_v_q, nb_q, clr_q;
  logic [PW-1:0]    top_cur_q;
  logic [1:0]       top_col_q;
  // Result register
  logic             out_valid_q, bip_q, err_q;

  // Memory ports
  logic             head_we, head_re, ent_we, ent_re, col_we, col_re, stk_we, stk_re;
  logic [VIW-1:0]   head_waddr, head_raddr, col_waddr, col_raddr, stk_waddr, stk_raddr;
  logic [PW-1:0]    head_wdata, head_rdata;
  logic [EIW-1:0]   ent_waddr, ent_raddr;
  logic [EW-1:0]    ent_wdata, ent_rdata;
  logic [1:0]       col_wdata, col_rdata;
  logic [FW-1:0]    stk_wdata, stk_rdata;

  logic [31:0]      n32, a32, b32;
  logic             bad;
  logic [VIW-1:0]   a_idx, b_idx, v_idx, ent_nb_idx;
  logic [VTX_W-1:0] ent_nb;
  logic [PW-1:0]    ent_next;
  logic [1:0]       other_col;

  // Effective vertex count and edge screening
  always_comb begin
    if (vertex_count_i == '0) begin
      n32 = 32'd1;
    end else if (32'(vertex_count_i) > MAX_VERTICES) begin
      n32 = MAX_VERTICES;
    end else begin
      n32 = 32'(vertex_count_i);
    end
    a32 = 32'(end_a_i);
    b32 = 32'(end_b_i);
    bad = (a32 == 32'd0) || (b32 == 32'd0) || (a32 > n32) || (b32 > n32) ||
          (32'(e_q) + 32'd2 > ED);
  end

  assign a_idx      = VIW'(32'(a_q) - 32'd1);
  assign b_idx      = VIW'(32'(b_q) - 32'd1);
  assign v_idx      = v_q[VIW-1:0];
  assign ent_nb     = ent_rdata[EW-1:PW];
  assign ent_next   = ent_rdata[PW-1:0];
  assign ent_nb_idx = VIW'(32'(ent_nb) - 32'd1);
  assign other_col  = (top_col_q == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;

  // Steer memory ports from the command
  always_comb begin
    head_we    = (cmd_i.op == CMD_CLEAR) || (cmd_i.op == CMD_WR_A) || (cmd_i.op == CMD_WR_B);
    head_waddr = (cmd_i.op == CMD_CLEAR) ? clr_q : ((cmd_i.op == CMD_WR_A) ? a_idx : b_idx);
    head_wdata = (cmd_i.op == CMD_CLEAR) ? '0 : e_q + PW'(1);
    head_re    = (cmd_i.op == CMD_RD_HA) || (cmd_i.op == CMD_RD_HB) ||
                 (cmd_i.op == CMD_START) || (cmd_i.op == CMD_PUSH_WR);
    case (cmd_i.op)
      CMD_RD_HA: head_raddr = a_idx;
      CMD_RD_HB: head_raddr = b_idx;
      CMD_START: head_raddr = v_idx;
      default:   head_raddr = nb_q;
    endcase

    ent_we    = (cmd_i.op == CMD_WR_A) || (cmd_i.op == CMD_WR_B);
    ent_waddr = e_q[EIW-1:0];
    ent_wdata = (cmd_i.op == CMD_WR_A) ? {b_q, head_rdata} : {a_q, head_rdata};
    ent_re    = (cmd_i.op == CMD_ENT_RD);
    ent_raddr = EIW'(top_cur_q - PW'(1));

    col_we    = (cmd_i.op == CMD_CLEAR) || (cmd_i.op == CMD_START) ||
                (cmd_i.op == CMD_PUSH_WR);
    case (cmd_i.op)
      CMD_CLEAR: begin
        col_waddr = clr_q;
        col_wdata = COLOR_NONE;
      end
      CMD_START: begin
        col_waddr = v_idx;
        col_wdata = COLOR_ONE;
      end
      default: begin
        col_waddr = nb_q;
        col_wdata = other_col;
      end
    endcase
    col_re    = (cmd_i.op == CMD_SCAN_RD) || (cmd_i.op == CMD_ENT);
    col_raddr = (cmd_i.op == CMD_SCAN_RD) ? v_idx : ent_nb_idx;

    stk_we    = (cmd_i.op == CMD_PUSH_WR);
    stk_waddr = VIW'(depth_q - NW'(1));
    stk_wdata = {top_v_q, top_cur_q, top_col_q};
    stk_re    = (cmd_i.op == CMD_POP_RD);
    stk_raddr = VIW'(depth_q - NW'(2));
  end

  bgc_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  bgc_ram #(.WIDTH(EW), .DEPTH(ED)) u_entry (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  bgc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_color (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .re_i(col_re), .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  bgc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q         <= '0;
      error_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_CLEAR:  clr_q   <= clr_q + VIW'(1);
        CMD_ACCEPT: error_q <= error_q | bad;
        CMD_WR_A:   e_q     <= e_q + PW'(1);
        CMD_WR_B:   e_q     <= e_q + PW'(1);
        default:    ;
      endcase
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        error_q     <= 1'b0;
        e_q         <= '0;
        clr_q       <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Edge, walk and result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_ACCEPT: begin
        a_q       <= end_a_i;
        b_q       <= end_b_i;
        last_q    <= last_edge_i;
        edge_ok_q <= !bad;
        ok_q      <= 1'b1;
        v_q       <= '0;
      end
      CMD_ROOT: begin
        top_v_q   <= v_idx;
        top_cur_q <= head_rdata;
        top_col_q <= COLOR_ONE;
        depth_q   <= NW'(1);
      end
      CMD_NEXT_V: v_q <= v_q + NW'(1);
      CMD_POP_RD: depth_q <= depth_q - NW'(1);
      CMD_ENT: begin
        top_cur_q <= ent_next;
        nb_q      <= ent_nb_idx;
      end
      CMD_PUSH: begin
        top_v_q   <= nb_q;
        top_cur_q <= head_rdata;
        top_col_q <= other_col;
        depth_q   <= depth_q + NW'(1);
      end
      default: ;
    endcase
    if (cmd_i.pop) {top_v_q, top_cur_q, top_col_q} <= stk_rdata;
    if (cmd_i.fail) ok_q <= 1'b0;
    if (cmd_i.finish) begin
      bip_q <= ok_q;
      err_q <= error_q;
    end
  end

  // Status to the controller
  always_comb begin
    status_o.edge_ok     = edge_ok_q;
    status_o.last        = last_q;
    status_o.clr_last    = (clr_q == VIW'(MAX_VERTICES - 1));
    status_o.scan_done   = (32'(v_q) >= n32);
    status_o.scan_free   = (col_rdata == COLOR_NONE);
    status_o.cur_null    = (top_cur_q == '0);
    status_o.depth_one   = (depth_q == NW'(1));
    status_o.nb_skip     = (ent_nb == '0) || (32'(ent_nb) > MAX_VERTICES);
    status_o.nb_free     = (col_rdata == COLOR_NONE);
    status_o.nb_conflict = (col_rdata == top_col_q);
    status_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign is_bipartite_o = bip_q;
  assign load_error_o   = err_q;

  // Result register is never overwritten while waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten");

  // List fill never passes the entry store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(e_q) <= ED)
    else $error("entry count overflow");

  // Entries are fetched only through a live cursor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_ENT_RD) |-> (top_cur_q != '0))
    else $error("entry read through null cursor");

  // A push writes a frame below the current top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_PUSH_WR) |-> (depth_q != '0) && (32'(depth_q) < MAX_VERTICES))
    else $error("stack push out of range");

endmodule

// File: sv/bipartite_graph_check.sv
// Edge load: accept, then a head read and a list write for each end; a dropped edge is
// only accepted and screened. Check on the last edge: each vertex is scanned by a color
// read and a test, a walk starts at each free vertex, each list entry walked is read and
// its neighbour tested, a new vertex is pushed, a stacked vertex is popped on return, a
// finished walk resumes the scan, and then the result is issued. After each result a sweep
// clears all heads and colors. Reset is asynchronous, active low, and starts the same sweep.
module bipartite_graph_check import bgc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bgc_edge_if.sink          edge_i,
  bgc_result_if.source      result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] vertex_count_q;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_ADDR_VERTEX_COUNT)) begin
      vertex_count_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == REG_ADDR_VERTEX_COUNT) ? APB_DW'(vertex_count_q) : '0;

  bgc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (edge_i.valid),
    .in_ready_o (edge_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bgc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .vertex_count_i (vertex_count_q),
    .end_a_i        (edge_i.end_a),
    .end_b_i        (edge_i.end_b),
    .last_edge_i    (edge_i.last_edge),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .is_bipartite_o (result_o.is_bipartite),
    .load_error_o   (result_o.load_error)
  );

endmodule

// File: tb/sv/bipartite_graph_check_tb.sv
module bipartite_graph_check_tb;
  import bgc_pkg::*;

  localparam int unsigned NV = MAX_VERTICES_DEF;
  localparam int unsigned NE = MAX_EDGES_DEF;
  localparam int unsigned LIMIT = 4000000;

  typedef struct packed {
    logic is_bipartite;
    logic load_error;
  } verdict_t;

  // Graph model: stores the edge list of the current graph and decides the
  // two-coloring when the last edge arrives
  class graph_scoreboard;
    int unsigned count_reg;
    int unsigned eu [$];
    int unsigned ev [$];
    bit dropped;
    verdict_t pending [$];
    int unsigned errors;

    function new();
      count_reg = NV;
      dropped = 0;
      errors = 0;
    endfunction

    function int unsigned span();
      if (count_reg == 0) return 1;
      if (count_reg > NV) return NV;
      return count_reg;
    endfunction

    // Two-color by a flood over adjacency; a walk order does not change
    // whether a conflict exists in a component, and any conflict stops all
    function bit colorable(int unsigned n);
      int unsigned adj [int unsigned][$];
      int unsigned color [int unsigned];
      int unsigned work [$];
      int unsigned x;
      int unsigned y;
      int unsigned bound;
      for (int i = 0; i < eu.size(); i++) begin
        if (!adj.exists(eu[i])) adj[eu[i]] = {};
        if (!adj.exists(ev[i])) adj[ev[i]] = {};
        adj[eu[i]].insert(adj[eu[i]].size(), ev[i]);
        adj[ev[i]].insert(adj[ev[i]].size(), eu[i]);
      end
      // stored edges beyond the current count are still reached by walks
      bound = n;
      foreach (adj[k]) if (k > bound) bound = k;
      for (int unsigned s = 1; s <= bound; s++) begin
        if (!adj.exists(s) || color.exists(s)) continue;
        if (s > n) continue;
        color[s] = 1;
        work.insert(work.size(), s);
        while (work.size() > 0) begin
          x = work.pop_back();
          foreach (adj[x][j]) begin
            y = adj[x][j];
            if (!color.exists(y)) begin
              color[y] = 3 - color[x];
              work.insert(work.size(), y);
            end else if (color[y] == color[x]) begin
              return 0;
            end
          end
        end
      end
      return 1;
    endfunction

    function void note_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b, logic last);
      int unsigned n;
      verdict_t v;
      n = span();
      if (a == 0 || b == 0 || a > n || b > n || eu.size() >= NE) begin
        dropped = 1;
      end else begin
        eu.insert(eu.size(), 32'(a));
        ev.insert(ev.size(), 32'(b));
      end
      if (last) begin
        v.is_bipartite = colorable(n);
        v.load_error = dropped;
        pending.insert(pending.size(), v);
        eu.delete();
        ev.delete();
        dropped = 0;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %b", $time, got);
        return;
      end
      want = pending.pop_front();
      if (want.is_bipartite !== got.is_bipartite) begin
        errors++;
        $display("%0t: is_bipartite expected %b actual %b", $time,
                 want.is_bipartite, got.is_bipartite);
      end
      if (want.load_error !== got.load_error) begin
        errors++;
        $display("%0t: load_error expected %b actual %b", $time,
                 want.load_error, got.load_error);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;
  int unsigned src_idle = 24;
  int unsigned snk_idle = 85;
  longint unsigned cycles = 0;
  graph_scoreboard sb;

  bgc_edge_if   edge_ch ();
  bgc_result_if res_ch ();

  bipartite_graph_check DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .edge_i(edge_ch.sink), .result_o(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall, check each result transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        sb.check_verdict({res_ch.is_bipartite, res_ch.load_error});
      res_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic write_count(logic [CFG_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_ADDR_VERTEX_COUNT;
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.count_reg = value;
    // read back the register
    @(posedge clk_i);
    if (prdata[CFG_W-1:0] !== value) begin
      sb.errors++;
      $display("%0t: vertex_count expected %0d actual %0d", $time, value,
               prdata[CFG_W-1:0]);
    end
  endtask

  // Offer one edge, holding it until the transfer
  task automatic send_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b, logic last);
    while ($urandom_range(99) < src_idle) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.end_a <= a;
    edge_ch.end_b <= b;
    edge_ch.last_edge <= last;
    do @(posedge clk_i); while (!edge_ch.ready);
    sb.note_edge(a, b, last);
  endtask

  // Drain results, then wait out the clearing sweep so the block is idle
  task automatic settle();
    edge_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (NV + 64) @(posedge clk_i);
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(int unsigned n);
    if ($urandom_range(49) == 0) return VTX_W'($urandom);
    return VTX_W'($urandom_range(n, 1));
  endfunction

  // One random graph: a ring path (even or odd ring once it closes), odd-to-even edges or random edges
  task automatic random_graph(int unsigned n);
    int unsigned m;
    int unsigned kind;
    logic [VTX_W-1:0] a, b;
    m = $urandom_range(12, 1);
    kind = $urandom_range(3);
    for (int unsigned i = 0; i < m; i++) begin
      if (kind == 0 && n > 1) begin
        a = VTX_W'(i % n + 1);
        b = VTX_W'((i + 1) % n + 1);
      end else if (kind == 1) begin
        // bipartite by construction when n is at least 2: odd to even
        a = VTX_W'(($urandom_range((n - 1) / 2) * 2 + 1));
        b = VTX_W'((n >= 2) ? $urandom_range(n / 2, 1) * 2 : 1);
      end else begin
        a = pick_vertex(n);
        b = pick_vertex(n);
      end
      send_edge(a, b, i == m - 1);
    end
  endtask

  task automatic random_phase(int unsigned edges_target);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    n = sb.span();
    while (sent < edges_target) begin
      random_graph((n > 24 && $urandom_range(3) != 0) ? $urandom_range(24, 2) : n);
      sent += 6;
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    edge_ch.valid <= 1'b0;
    edge_ch.end_a <= '0;
    edge_ch.end_b <= '0;
    edge_ch.last_edge <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settle();

    // Directed: extremes, self-loop, odd and even cycles, range errors
    send_edge(11'd1, 11'd1024, 1'b1);
    send_edge(11'd1024, 11'd1024, 1'b1);
    send_edge(11'd1, 11'd2, 1'b0);
    send_edge(11'd2, 11'd3, 1'b0);
    send_edge(11'd3, 11'd1, 1'b1);
    send_edge(11'd1, 11'd2, 1'b0);
    send_edge(11'd2, 11'd3, 1'b0);
    send_edge(11'd3, 11'd4, 1'b0);
    send_edge(11'd4, 11'd1, 1'b1);
    send_edge(11'd0, 11'd5, 1'b1);
    send_edge(11'd7, 11'd2047, 1'b0);
    send_edge(11'd5, 11'd6, 1'b1);
    send_edge(11'h555, 11'h2AA, 1'b1);
    settle();

    write_count(11'd0);
    send_edge(11'd1, 11'd1, 1'b1);
    send_edge(11'd1, 11'd2, 1'b1);
    settle();
    write_count(11'd2047);
    send_edge(11'd1024, 11'd1025, 1'b1);
    send_edge(11'd1023, 11'd1024, 1'b1);
    settle();

    // Mid-graph change: edge to vertex 9 kept after count shrinks
    write_count(11'd10);
    send_edge(11'd1, 11'd9, 1'b0);
    settle();
    write_count(11'd4);
    send_edge(11'd1, 11'd2, 1'b1);
    settle();

    write_count(11'd16);
    random_phase(500);
    settle();
    src_idle = 85;
    snk_idle = 24;
    write_count(11'd1);
    random_phase(100);
    settle();
    write_count(11'd7);
    random_phase(400);
    settle();
    src_idle = 0;
    snk_idle = 0;
    write_count(11'd1024);
    random_phase(400);
    settle();
    write_count(11'd3);
    random_phase(100);

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bgc_pkg.sv
sv/bgc_if.sv
sv/bgc_ram.sv
sv/bgc_ctrl.sv
sv/bgc_dp.sv
sv/bipartite_graph_check.sv
tb/sv/bipartite_graph_check_tb.sv
